@@ rtl/core/set_assoc_cache_lru_lookup_defines.svh @@
// Assertion macros for the set-associative cache lookup block.
// Included by the top level; has no dependencies of its own.
`ifndef SET_ASSOC_CACHE_LRU_LOOKUP_DEFINES_SVH
`define SET_ASSOC_CACHE_LRU_LOOKUP_DEFINES_SVH
`ifndef SYNTH
// Checks a property that is not looked at while reset is high.
`define SALRU_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("cache lookup check failed");
// Checks a property that must also hold across reset.
`define SALRU_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("cache lookup reset check failed");
`else
`define SALRU_ASSERT(lbl, prop)
`define SALRU_ASSERT_RST(lbl, prop)
`endif
`endif

@@ rtl/core/salru_pkg.sv @@
// Shared types and access-kind codes for the set-associative cache lookup.
// No dependencies; used by salru_store, salru_update and the top level.
package salru_pkg;

  // Access kinds carried with each request beat.
  localparam logic [1:0] KIND_IREAD  = 2'd0;
  localparam logic [1:0] KIND_DREAD  = 2'd1;
  localparam logic [1:0] KIND_DWRITE = 2'd2;

  // Read and write strobes for the set store.
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } store_ctl_t;

  // Outcome of one lookup, used to advance the counters.
  typedef struct packed {
    logic hit;
    logic instr_miss;
    logic data_miss;
    logic write_miss;
  } lookup_stat_t;

endpackage

@@ rtl/core/salru_index.sv @@
// Splits a byte address into set index and stored tag.
// Depends on nothing; instantiated by the top level.
module salru_index #(
  parameter int SETS        = 64,
  parameter int OFFSET_BITS = 5,
  parameter int ADDR_BITS   = 32,
  parameter int SET_BITS    = 6,
  parameter int TAG_BITS    = 21
) (
  input  logic [31:0]         address,
  output logic [SET_BITS-1:0] set_idx,
  output logic [TAG_BITS-1:0] tag
);

  localparam int  EFF_BITS = (ADDR_BITS < 32) ? ADDR_BITS : 32;
  localparam int  BLK_BITS = EFF_BITS - OFFSET_BITS;
  localparam int  LOG2S    = $clog2(SETS);
  localparam bit  POW2     = ((SETS & (SETS - 1)) == 0);

  // Residue of two to the power e, modulo the set count, at elaboration.
  function automatic int unsigned pow2_mod(input int unsigned e);
    int unsigned r;
    r = 1 % SETS;
    for (int unsigned i = 0; i < e; i++) begin
      r = (r * 2) % SETS;
    end
    return r;
  endfunction

  logic [BLK_BITS-1:0] block;
  logic [63:0]         block_ext;

  assign block     = address[EFF_BITS-1:OFFSET_BITS];
  assign block_ext = 64'(block);

  generate
    if (POW2) begin : g_pow2
      // Power-of-two set count: the index is a bit field and the tag the bits above it.
      if (LOG2S == 0) begin : g_one_set
        assign set_idx = '0;
      end else begin : g_many_sets
        assign set_idx = block_ext[SET_BITS-1:0];
      end
      assign tag = block_ext[TAG_BITS+LOG2S-1:LOG2S];
    end else begin : g_fold
      // Other set counts: the whole block address is kept as the tag, and the
      // index is a residue found by two folds of weighted bits and a final trim.
      localparam int L  = LOG2S;
      localparam int K1 = (BLK_BITS > L) ? BLK_BITS - L : 0;
      localparam int W1 = $clog2((K1 + 2) * SETS);
      localparam int K2 = W1 - L;
      localparam int W2 = $clog2((K2 + 2) * SETS);

      logic [W1-1:0] fold1;
      logic [W2-1:0] fold2;
      logic [W2-1:0] rem;

      always_comb begin
        fold1 = W1'(block_ext[L-1:0]);
        for (int j = 0; j < K1; j++) begin
          if (block_ext[L+j]) begin
            fold1 = fold1 + W1'(pow2_mod(L + j));
          end
        end
      end

      always_comb begin
        fold2 = W2'(fold1[L-1:0]);
        for (int j = 0; j < K2; j++) begin
          if (fold1[L+j]) begin
            fold2 = fold2 + W2'(pow2_mod(L + j));
          end
        end
      end

      // The second fold stays below a few multiples of the set count.
      always_comb begin
        rem = fold2;
        for (int q = 1; q <= K2 + 1; q++) begin
          if (fold2 >= W2'(q * SETS)) begin
            rem = fold2 - W2'(q * SETS);
          end
        end
      end

      assign set_idx = rem[SET_BITS-1:0];
      assign tag     = TAG_BITS'(block);
    end
  endgenerate

endmodule

@@ rtl/core/salru_store.sv @@
// Set store: one row per set holding tags, recency ranks and valid bits.
// Depends on salru_pkg; runs a clearing pass after reset.
module salru_store #(
  parameter int SETS     = 64,
  parameter int SET_BITS = 6,
  parameter int ROW_BITS = 96
) (
  input  logic                  clk,
  input  logic                  rst,
  input  salru_pkg::store_ctl_t ctl,
  input  logic [SET_BITS-1:0]   rd_set,
  input  logic [SET_BITS-1:0]   wr_set,
  input  logic [ROW_BITS-1:0]   wr_row,
  input  logic [ROW_BITS-1:0]   init_row,
  output logic [ROW_BITS-1:0]   rd_row,
  output logic                  busy
);

  logic [ROW_BITS-1:0] mem [SETS];
  logic                clr_active;
  logic [SET_BITS-1:0] clr_ptr;

  // Clearing pass: one row per cycle from set zero upwards.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_ptr    <= '0;
    end else if (clr_active) begin
      if (clr_ptr == SET_BITS'(SETS - 1)) begin
        clr_active <= 1'b0;
      end else begin
        clr_ptr <= clr_ptr + SET_BITS'(1);
      end
    end
  end

  // Row writes, from the clearing pass or from the finished lookup.
  always_ff @(posedge clk) begin
    if (clr_active) begin
      mem[clr_ptr] <= init_row;
    end else if (ctl.wr_en) begin
      mem[wr_set] <= wr_row;
    end
  end

  // Registered read; a row written in the same cycle is forwarded.
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      if (ctl.wr_en && (wr_set == rd_set)) begin
        rd_row <= wr_row;
      end else begin
        rd_row <= mem[rd_set];
      end
    end
  end

  assign busy = clr_active;

endmodule

@@ rtl/core/salru_update.sv @@
// Tag compare, victim choice and recency update for one set row.
// Depends on salru_pkg; purely combinational.
module salru_update #(
  parameter int WAYS      = 4,
  parameter int TAG_BITS  = 21,
  parameter int RANK_BITS = 2,
  parameter int ROW_BITS  = 96
) (
  input  logic [ROW_BITS-1:0]    row_in,
  input  logic [TAG_BITS-1:0]    tag,
  input  logic [1:0]             kind,
  output logic [ROW_BITS-1:0]    row_out,
  output logic [ROW_BITS-1:0]    init_row,
  output logic [RANK_BITS-1:0]   way_sel,
  output salru_pkg::lookup_stat_t stat
);

  logic [WAYS-1:0]                valid;
  logic [WAYS-1:0][RANK_BITS-1:0] rank;
  logic [WAYS-1:0][TAG_BITS-1:0]  tags;
  logic [WAYS-1:0]                valid_n;
  logic [WAYS-1:0][RANK_BITS-1:0] rank_n;
  logic [WAYS-1:0][TAG_BITS-1:0]  tags_n;
  logic [WAYS-1:0][RANK_BITS-1:0] rank_init;
  logic [WAYS-1:0]                match;
  logic                           hit;
  logic [RANK_BITS-1:0]           hit_way;
  logic [RANK_BITS-1:0]           free_way;
  logic [RANK_BITS-1:0]           lru_way;
  logic [RANK_BITS-1:0]           used_rank;

  assign {tags, rank, valid} = row_in;

  // Compare all ways at once and find the lowest matching, free and oldest ways.
  always_comb begin
    hit_way  = '0;
    free_way = '0;
    lru_way  = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      match[w] = valid[w] && (tags[w] == tag);
      if (match[w]) begin
        hit_way = RANK_BITS'(w);
      end
      if (!valid[w]) begin
        free_way = RANK_BITS'(w);
      end
      if (rank[w] == RANK_BITS'(WAYS - 1)) begin
        lru_way = RANK_BITS'(w);
      end
    end
  end

  assign hit = |match;

  always_comb begin
    if (hit) begin
      way_sel = hit_way;
    end else if (!(&valid)) begin
      way_sel = free_way;
    end else begin
      way_sel = lru_way;
    end
  end

  assign used_rank = rank[way_sel];

  // The used way becomes most recent; younger ways age by one.
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      valid_n[w] = valid[w];
      tags_n[w]  = tags[w];
      if (RANK_BITS'(w) == way_sel) begin
        rank_n[w] = '0;
        if (!hit) begin
          valid_n[w] = 1'b1;
          tags_n[w]  = tag;
        end
      end else if (rank[w] < used_rank) begin
        rank_n[w] = rank[w] + RANK_BITS'(1);
      end else begin
        rank_n[w] = rank[w];
      end
    end
  end

  assign row_out = {tags_n, rank_n, valid_n};

  // Row contents after reset: nothing valid, ranks in way order.
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      rank_init[w] = RANK_BITS'(w);
    end
  end

  assign init_row = {{(WAYS * TAG_BITS){1'b0}}, rank_init, {WAYS{1'b0}}};

  // Counter increments for this access.
  always_comb begin
    stat            = '0;
    stat.hit        = hit;
    case (kind)
      salru_pkg::KIND_IREAD:  stat.instr_miss = !hit;
      salru_pkg::KIND_DREAD:  stat.data_miss  = !hit;
      salru_pkg::KIND_DWRITE: stat.write_miss = !hit;
      default:                stat.hit        = hit;
    endcase
  end

endmodule

@@ rtl/core/set_assoc_cache_lru_lookup.sv @@
// Top level of the set-associative cache lookup with LRU replacement.
// Depends on salru_pkg, salru_index, salru_store, salru_update and the defines header.
//
// Channel  Valid      Stall      Fields
// req      req_valid  req_stall  kind, address
// rsp      rsp_valid  rsp_stall  hit, way, hit_count, instr_miss_count,
//                                data_miss_count, write_miss_count
//
// One access is taken every cycle while nothing stalls; each goes through the lookup
// stage into the result register. The rate is set by the read-modify-write of one
// set row per cycle; a row written in a cycle is forwarded to a read of the same set.
// After reset a clearing pass over every set runs with req_stall high.
// A stalled result holds the access behind it, which then stalls requests.
`include "set_assoc_cache_lru_lookup_defines.svh"

module set_assoc_cache_lru_lookup #(
  parameter int SETS        = 64,
  parameter int WAYS        = 4,
  parameter int OFFSET_BITS = 5,
  parameter int ADDR_BITS   = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [1:0]  kind,
  input  logic [31:0] address,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic        hit,
  output logic [1:0]  way,
  output logic [31:0] hit_count,
  output logic [31:0] instr_miss_count,
  output logic [31:0] data_miss_count,
  output logic [31:0] write_miss_count
);

  localparam int EFF_BITS  = (ADDR_BITS < 32) ? ADDR_BITS : 32;
  localparam int BLK_BITS  = EFF_BITS - OFFSET_BITS;
  localparam int LOG2S     = $clog2(SETS);
  localparam int SET_BITS  = (SETS > 1) ? LOG2S : 1;
  localparam bit POW2      = ((SETS & (SETS - 1)) == 0);
  localparam int TAG_BITS  = POW2 ? ((BLK_BITS > LOG2S) ? BLK_BITS - LOG2S : 1) : BLK_BITS;
  localparam int RANK_BITS = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int ROW_BITS  = WAYS * (TAG_BITS + RANK_BITS + 1);

  logic                    busy;
  logic                    accept;
  logic                    s1_adv;
  logic                    s1_valid;
  logic [1:0]              s1_kind;
  logic [SET_BITS-1:0]     s1_set;
  logic [TAG_BITS-1:0]     s1_tag;
  logic [SET_BITS-1:0]     req_set;
  logic [TAG_BITS-1:0]     req_tag;
  logic [ROW_BITS-1:0]     rd_row;
  logic [ROW_BITS-1:0]     row_new;
  logic [ROW_BITS-1:0]     init_row;
  logic [RANK_BITS-1:0]    way_sel;
  logic [3:0]              stat_bits;
  salru_pkg::lookup_stat_t stat;
  salru_pkg::store_ctl_t   ctl;

  // Handshake: the lookup stage moves on when the result register is free.
  assign s1_adv    = s1_valid && (!rsp_valid || !rsp_stall);
  assign req_stall = rst || busy || (s1_valid && !s1_adv);
  assign accept    = req_valid && !req_stall;
  assign ctl.rd_en = accept;
  assign ctl.wr_en = s1_adv;

  salru_index #(
    .SETS        (SETS),
    .OFFSET_BITS (OFFSET_BITS),
    .ADDR_BITS   (ADDR_BITS),
    .SET_BITS    (SET_BITS),
    .TAG_BITS    (TAG_BITS)
  ) u_index (
    .address (address),
    .set_idx (req_set),
    .tag     (req_tag)
  );

  salru_store #(
    .SETS     (SETS),
    .SET_BITS (SET_BITS),
    .ROW_BITS (ROW_BITS)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .rd_set   (req_set),
    .wr_set   (s1_set),
    .wr_row   (row_new),
    .init_row (init_row),
    .rd_row   (rd_row),
    .busy     (busy)
  );

  salru_update #(
    .WAYS      (WAYS),
    .TAG_BITS  (TAG_BITS),
    .RANK_BITS (RANK_BITS),
    .ROW_BITS  (ROW_BITS)
  ) u_update (
    .row_in   (rd_row),
    .tag      (s1_tag),
    .kind     (s1_kind),
    .row_out  (row_new),
    .init_row (init_row),
    .way_sel  (way_sel),
    .stat     (stat)
  );

  // Lookup stage: holds the accepted beat while its set row is read.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_kind <= kind;
      s1_set  <= req_set;
      s1_tag  <= req_tag;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (s1_adv) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      hit <= stat.hit;
      way <= 2'(way_sel);
    end
  end

  // The counters change only when a result is loaded, so they serve as its payload.
  always_ff @(posedge clk) begin
    if (rst) begin
      hit_count        <= '0;
      instr_miss_count <= '0;
      data_miss_count  <= '0;
      write_miss_count <= '0;
    end else if (s1_adv) begin
      if (stat.hit) begin
        hit_count <= hit_count + 32'd1;
      end
      if (stat.instr_miss) begin
        instr_miss_count <= instr_miss_count + 32'd1;
      end
      if (stat.data_miss) begin
        data_miss_count <= data_miss_count + 32'd1;
      end
      if (stat.write_miss) begin
        write_miss_count <= write_miss_count + 32'd1;
      end
    end
  end

  assign stat_bits = {stat.hit, stat.instr_miss, stat.data_miss, stat.write_miss};

  `SALRU_ASSERT_RST(a_clear_after_reset, rst |=> req_stall)
  `SALRU_ASSERT(a_result_follows, s1_adv |=> rsp_valid)
  `SALRU_ASSERT(a_single_outcome, s1_adv |-> $onehot0(stat_bits))
  `SALRU_ASSERT(a_stage_holds, s1_valid && !s1_adv |=> s1_valid && $stable(s1_set))

endmodule

@@ test/set_assoc_cache_lru_lookup_tb.sv @@
// Testbench for the set-associative cache lookup with LRU replacement.
// Holds a scoreboard class that predicts each lookup, and the top module that drives
// the block. Depends on salru_pkg and the set_assoc_cache_lru_lookup RTL.
`timescale 1ns / 1ps

localparam int CACHE_SETS        = 64;
localparam int CACHE_WAYS        = 4;
localparam int CACHE_OFFSET_BITS = 5;
localparam int unsigned CACHE_TAG_MAX = (32'hFFFF_FFFF >> CACHE_OFFSET_BITS) / CACHE_SETS;

// The access kind that the package leaves unnamed; its hits are counted but its misses are not.
localparam logic [1:0] KIND_RESERVED = 2'd3;

// Fields of one result beat.
typedef struct {
  logic        hit;
  logic [1:0]  way;
  logic [31:0] hits;
  logic [31:0] instr_misses;
  logic [31:0] data_misses;
  logic [31:0] write_misses;
} lookup_result_t;

class cache_scoreboard;
  logic [31:0]    line_tag   [CACHE_SETS][CACHE_WAYS];
  bit             line_valid [CACHE_SETS][CACHE_WAYS];
  int unsigned    line_rank  [CACHE_SETS][CACHE_WAYS];
  logic [31:0]    hits, instr_misses, data_misses, write_misses;
  lookup_result_t pending[$];
  int unsigned    mismatches;

  // Every way starts invalid, with its rank equal to its way number.
  function new();
    for (int s = 0; s < CACHE_SETS; s++) begin
      for (int w = 0; w < CACHE_WAYS; w++) begin
        line_tag[s][w]   = '0;
        line_valid[s][w] = 1'b0;
        line_rank[s][w]  = w;
      end
    end
    hits = '0;
    instr_misses = '0;
    data_misses = '0;
    write_misses = '0;
    mismatches = 0;
  endfunction

  // Works out the lookup of an accepted request beat and queues its result.
  function void note_access(logic [1:0] k, logic [31:0] a);
    logic [31:0]    block, tag;
    int unsigned    set_idx, chosen, old_rank;
    bit             found, have_free;
    lookup_result_t r;
    block   = a >> CACHE_OFFSET_BITS;
    set_idx = block % CACHE_SETS;
    tag     = block / CACHE_SETS;
    found   = 1'b0;
    chosen  = 0;
    for (int w = 0; w < CACHE_WAYS; w++) begin
      if (!found && line_valid[set_idx][w] && line_tag[set_idx][w] == tag) begin
        found  = 1'b1;
        chosen = w;
      end
    end
    if (found) begin
      hits++;
    end else begin
      // Fill the lowest invalid way, or else replace the least recently used one.
      have_free = 1'b0;
      for (int w = 0; w < CACHE_WAYS; w++) begin
        if (!have_free && !line_valid[set_idx][w]) begin
          have_free = 1'b1;
          chosen    = w;
        end
      end
      if (!have_free) begin
        for (int w = 0; w < CACHE_WAYS; w++) begin
          if (line_rank[set_idx][w] == CACHE_WAYS - 1) chosen = w;
        end
      end
      line_tag[set_idx][chosen]   = tag;
      line_valid[set_idx][chosen] = 1'b1;
      case (k)
        salru_pkg::KIND_IREAD:  instr_misses++;
        salru_pkg::KIND_DREAD:  data_misses++;
        salru_pkg::KIND_DWRITE: write_misses++;
        default: ;
      endcase
    end
    // Ways more recent than the chosen one age by one; the chosen one becomes newest.
    old_rank = line_rank[set_idx][chosen];
    for (int w = 0; w < CACHE_WAYS; w++) begin
      if (line_rank[set_idx][w] < old_rank) line_rank[set_idx][w]++;
    end
    line_rank[set_idx][chosen] = 0;
    r.hit          = found;
    r.way          = chosen[1:0];
    r.hits         = hits;
    r.instr_misses = instr_misses;
    r.data_misses  = data_misses;
    r.write_misses = write_misses;
    pending.push_back(r);
  endfunction

  function void compare_field(string name, logic [31:0] want, logic [31:0] seen);
    if (seen !== want) begin
      $error("%s: expected %0d, got %0d", name, want, seen);
      mismatches++;
    end
  endfunction

  // Compares an accepted result beat with the oldest prediction.
  function void check_result(lookup_result_t got);
    lookup_result_t want;
    if (pending.size() == 0) begin
      $error("result beat with no access outstanding: hit %0d way %0d", got.hit, got.way);
      mismatches++;
    end else begin
      want = pending.pop_front();
      compare_field("hit", want.hit, got.hit);
      compare_field("way", want.way, got.way);
      compare_field("hit_count", want.hits, got.hits);
      compare_field("instr_miss_count", want.instr_misses, got.instr_misses);
      compare_field("data_miss_count", want.data_misses, got.data_misses);
      compare_field("write_miss_count", want.write_misses, got.write_misses);
    end
  endfunction

  function int unsigned outstanding();
    return pending.size();
  endfunction
endclass

module set_assoc_cache_lru_lookup_tb;

  localparam int RANDOM_ITEMS = 1000;
  localparam int CYCLE_LIMIT  = 200000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_stall;
  logic [1:0]  kind = salru_pkg::KIND_IREAD;
  logic [31:0] address = '0;
  logic        rsp_valid;
  logic        rsp_stall = 1'b0;
  logic        hit;
  logic [1:0]  way;
  logic [31:0] hit_count, instr_miss_count, data_miss_count, write_miss_count;

  cache_scoreboard sb;
  bit              sender_idles = 1'b1;

  set_assoc_cache_lru_lookup #(
    .SETS        (CACHE_SETS),
    .WAYS        (CACHE_WAYS),
    .OFFSET_BITS (CACHE_OFFSET_BITS),
    .ADDR_BITS   (32)
  ) dut (
    .clk              (clk),
    .rst              (rst),
    .req_valid        (req_valid),
    .req_stall        (req_stall),
    .kind             (kind),
    .address          (address),
    .rsp_valid        (rsp_valid),
    .rsp_stall        (rsp_stall),
    .hit              (hit),
    .way              (way),
    .hit_count        (hit_count),
    .instr_miss_count (instr_miss_count),
    .data_miss_count  (data_miss_count),
    .write_miss_count (write_miss_count)
  );

  always #4 clk = ~clk;

  function automatic logic [31:0] block_address(int unsigned tag, int unsigned set_idx,
                                                 int unsigned offset);
    return ((tag * CACHE_SETS + set_idx) << CACHE_OFFSET_BITS) | offset;
  endfunction

  // Offers one request beat, after an optional random gap, and waits for it to be taken.
  task automatic send_access(input logic [1:0] k, input logic [31:0] a);
    while (sender_idles && $urandom_range(99) < 9) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    kind      <= k;
    address   <= a;
    do @(posedge clk); while (req_stall);
    sb.note_access(k, a);
  endtask

  task automatic wait_drained();
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  // Request side: directed accesses, then random ones aimed at a few busy sets.
  initial begin : stimulus
    logic [31:0] hot_sets [4];
    logic [31:0] hot_tags [6];
    logic [1:0]  k;
    logic [31:0] a;
    int unsigned pick;
    sb = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    send_access(salru_pkg::KIND_IREAD, 32'h0000_0000);
    send_access(salru_pkg::KIND_DREAD, 32'h0000_001F);
    send_access(salru_pkg::KIND_DWRITE, 32'hFFFF_FFFF);
    send_access(KIND_RESERVED, 32'hFFFF_FFE0);
    // An unnamed kind that misses still fills a way but counts nowhere.
    send_access(KIND_RESERVED, block_address(1, 0, 0));
    send_access(salru_pkg::KIND_IREAD, block_address(2, 0, 3));
    send_access(salru_pkg::KIND_DWRITE, block_address(3, 0, 7));
    send_access(salru_pkg::KIND_DREAD, block_address(0, 0, 0));
    // Set 0 is full now, so these misses replace the least recently used way.
    send_access(salru_pkg::KIND_IREAD, block_address(4, 0, 0));
    send_access(salru_pkg::KIND_DREAD, block_address(1, 0, 0));
    send_access(salru_pkg::KIND_DWRITE, block_address(2, 0, 31));
    send_access(KIND_RESERVED, block_address(0, 0, 0));
    send_access(salru_pkg::KIND_DREAD, 32'hAAAA_AAAA);
    send_access(salru_pkg::KIND_DWRITE, 32'h5555_5555);
    send_access(salru_pkg::KIND_IREAD, 32'hAAAA_AAAA);
    send_access(salru_pkg::KIND_IREAD, block_address(CACHE_TAG_MAX, 0, 0));
    send_access(salru_pkg::KIND_DREAD, block_address(0, CACHE_SETS - 1, 0));
    send_access(salru_pkg::KIND_DWRITE, block_address(CACHE_TAG_MAX, 0, 1));
    req_valid <= 1'b0;
    wait_drained();

    for (int i = 0; i < 4; i++) hot_sets[i] = $urandom_range(CACHE_SETS - 1);
    for (int i = 0; i < 6; i++) hot_tags[i] = $urandom_range(CACHE_TAG_MAX);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      sender_idles = !(i >= 200 && i < 400);
      // Halfway through, hold requests back until every result has come home.
      if (i == RANDOM_ITEMS / 2) begin
        req_valid <= 1'b0;
        wait_drained();
      end
      pick = $urandom_range(9);
      k = (pick < 3) ? salru_pkg::KIND_IREAD : (pick < 6) ? salru_pkg::KIND_DREAD :
          (pick < 9) ? salru_pkg::KIND_DWRITE : KIND_RESERVED;
      // Six tags over four ways in a few sets give a mix of hits and replacements.
      if ($urandom_range(9) < 7) begin
        a = block_address(hot_tags[$urandom_range(5)], hot_sets[$urandom_range(3)],
                          $urandom_range((1 << CACHE_OFFSET_BITS) - 1));
      end else begin
        a = $urandom();
      end
      send_access(k, a);
    end
    req_valid <= 1'b0;
    wait_drained();
    repeat (4) @(posedge clk);

    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Result side: checks each beat, stalls at random and twice holds off for a long stretch.
  initial begin : result_sink
    lookup_result_t got;
    int unsigned    results_seen;
    int unsigned    hold_left;
    results_seen = 0;
    hold_left    = 0;
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (rsp_valid && !rsp_stall) begin
        got.hit          = hit;
        got.way          = way;
        got.hits         = hit_count;
        got.instr_misses = instr_miss_count;
        got.data_misses  = data_miss_count;
        got.write_misses = write_miss_count;
        sb.check_result(got);
        results_seen++;
        if (results_seen == 300 || results_seen == 700) hold_left = 250;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= (results_seen < 500 || results_seen >= 650) && $urandom_range(99) < 9;
      end
    end
  end

  // Ends a run that hangs.
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

@@ set_assoc_cache_lru_lookup.f @@
+incdir+rtl/core
rtl/core/salru_pkg.sv
rtl/core/salru_index.sv
rtl/core/salru_store.sv
rtl/core/salru_update.sv
rtl/core/set_assoc_cache_lru_lookup.sv
test/set_assoc_cache_lru_lookup_tb.sv
